// ===== hw/rtl/balance_cascade_pid_defines.svh =====
// Assertion macros for the balance controller.
`ifndef BALANCE_CASCADE_PID_DEFINES_SVH
`define BALANCE_CASCADE_PID_DEFINES_SVH

// Same-cycle implication, reset masked.
`define BCP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, reset masked.
`define BCP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/bcp_pkg.sv =====
// Shared types and constants of the balance controller.
package bcp_pkg;

	localparam int FILTER_ALPHA_Q16_DEF = 45875;

	localparam logic signed [31:0] VERT_KP_RST      = -32'sd65536000;
	localparam logic signed [31:0] VERT_KD_RST      = -32'sd327680;
	localparam logic signed [31:0] VEL_KP_RST       = -32'sd7864;
	localparam logic signed [31:0] VEL_KI_RST       = -32'sd39;
	localparam logic signed [16:0] ANGLE_OFFSET_RST = -17'sd256;
	localparam logic [15:0]        TILT_LIMIT_RST   = 16'd8960;
	localparam logic [14:0]        PWM_LIMIT_RST    = 15'd7000;
	localparam logic [14:0]        INTEG_LIMIT_RST  = 15'd10000;

	typedef enum logic [2:0] {
		REG_VERT_KP      = 3'd0,
		REG_VERT_KD      = 3'd1,
		REG_VEL_KP       = 3'd2,
		REG_VEL_KI       = 3'd3,
		REG_ANGLE_OFFSET = 3'd4,
		REG_TILT_LIMIT   = 3'd5,
		REG_PWM_LIMIT    = 3'd6,
		REG_INTEG_LIMIT  = 3'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_F0,
		ST_F1,
		ST_F2,
		ST_I0,
		ST_O1,
		ST_O2,
		ST_P0,
		ST_P1,
		ST_P2
	} seq_state_t;

	// multiplier operand pairs
	typedef enum logic [2:0] {
		MS_NONE,
		MS_FILT_OLD,
		MS_FILT_NEW,
		MS_VEL_P,
		MS_VEL_I,
		MS_VERT_P,
		MS_VERT_D
	} mul_sel_t;

	// accumulator / shared adder operations
	typedef enum logic [2:0] {
		AOP_HOLD,
		AOP_LOAD,
		AOP_LOAD_SH,
		AOP_SUM,
		AOP_TARGET
	} acc_op_t;

	typedef struct packed {
		logic     busy;
		logic     mul_en;
		mul_sel_t msel;
		acc_op_t  aop;
		logic     fe_we;
		logic     si_we;
		logic     out_we;
	} ctl_t;

	typedef struct packed {
		logic signed [31:0] vert_kp;
		logic signed [31:0] vert_kd;
		logic signed [31:0] vel_kp;
		logic signed [31:0] vel_ki;
		logic [14:0]        pwm_limit;
		logic [14:0]        integ_limit;
	} cfg_t;

	// per-request operands prepared at acceptance
	typedef struct packed {
		logic signed [16:0] err;    // 0 - enc_speed
		logic signed [17:0] dlt;    // angle_offset - roll_angle, 1/256 deg
		logic signed [28:0] nrate;  // -(roll_rate * 256)
	} opnd_t;

endpackage

// ===== hw/rtl/bcp_ctrl.sv =====
// Step sequencer driving the shared multiply-accumulate datapath.
module bcp_ctrl
	import bcp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic out_free,
	output ctl_t ctl
);

	seq_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_nx = ST_F0;
			end
			ST_F0: state_nx = ST_F1;
			ST_F1: state_nx = ST_F2;
			ST_F2: state_nx = ST_I0;
			ST_I0: state_nx = ST_O1;
			ST_O1: state_nx = ST_O2;
			ST_O2: state_nx = ST_P0;
			ST_P0: state_nx = ST_P1;
			ST_P1: state_nx = ST_P2;
			ST_P2: begin
				if (out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl        = '0;
		ctl.msel   = MS_NONE;
		ctl.aop    = AOP_HOLD;
		ctl.busy   = (state_q != ST_IDLE);
		case (state_q)
			ST_F0: begin
				ctl.mul_en = 1'b1;
				ctl.msel   = MS_FILT_OLD;
			end
			ST_F1: begin
				ctl.mul_en = 1'b1;
				ctl.msel   = MS_FILT_NEW;
				ctl.aop    = AOP_LOAD_SH;
			end
			ST_F2: begin
				ctl.aop    = AOP_SUM;
				ctl.fe_we  = 1'b1;
			end
			ST_I0: begin
				ctl.si_we  = 1'b1;
				ctl.mul_en = 1'b1;
				ctl.msel   = MS_VEL_P;
			end
			ST_O1: begin
				ctl.mul_en = 1'b1;
				ctl.msel   = MS_VEL_I;
				ctl.aop    = AOP_LOAD_SH;
			end
			ST_O2: begin
				ctl.aop    = AOP_TARGET;
			end
			ST_P0: begin
				ctl.mul_en = 1'b1;
				ctl.msel   = MS_VERT_P;
			end
			ST_P1: begin
				ctl.mul_en = 1'b1;
				ctl.msel   = MS_VERT_D;
				ctl.aop    = AOP_LOAD;
			end
			ST_P2: begin
				ctl.aop    = AOP_SUM;
				ctl.out_we = out_free;
			end
			default: begin
				ctl.aop    = AOP_HOLD;
			end
		endcase
	end

endmodule

// ===== hw/rtl/bcp_dp.sv =====
// Shared multiplier, accumulator and loop state of the balance controller.
module bcp_dp
	import bcp_pkg::*;
#(
	parameter int FILTER_ALPHA_Q16 = FILTER_ALPHA_Q16_DEF
)(
	input  logic               clk,
	input  logic               arst_n,
	input  ctl_t               ctl,
	input  cfg_t               cfg,
	input  opnd_t              opnd,
	output logic signed [15:0] drive
);

	localparam int ALPHA_C = 65536 - FILTER_ALPHA_Q16;
	localparam logic signed [65:0] I32_MAX_X = 66'sd2147483647;
	localparam logic signed [65:0] I32_MIN_X = -66'sd2147483648;

	function automatic logic signed [31:0] clamp32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > I32_MAX_X) r = 32'sh7FFF_FFFF;
		else if (v < I32_MIN_X) r = 32'sh8000_0000;
		else r = v[31:0];
		return r;
	endfunction

	logic signed [31:0] fe_q, si_q;
	logic signed [65:0] prod_q, acc_q;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod_sh, add_b, add_c, sum_w;
	logic signed [31:0] sum_c32;

	// operand select for the single multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctl.msel)
			MS_FILT_OLD: begin
				mul_a = 33'(fe_q);
				mul_b = 33'(FILTER_ALPHA_Q16);
			end
			MS_FILT_NEW: begin
				mul_a = 33'(opnd.err);
				mul_b = 33'(ALPHA_C);
			end
			MS_VEL_P: begin
				mul_a = 33'(fe_q);
				mul_b = 33'(cfg.vel_kp);
			end
			MS_VEL_I: begin
				mul_a = 33'(si_q);
				mul_b = 33'(cfg.vel_ki);
			end
			MS_VERT_P: begin
				mul_a = 33'($signed(acc_q[31:0]));
				mul_b = 33'(cfg.vert_kp);
			end
			MS_VERT_D: begin
				mul_a = 33'(opnd.nrate);
				mul_b = 33'(cfg.vert_kd);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_en) prod_q <= mul_a * mul_b;
	end

	// shared adder: acc + product (shifted for the target step) + angle term
	assign prod_sh = prod_q >>> 16;
	assign add_b   = (ctl.aop == AOP_TARGET) ? prod_sh : prod_q;
	assign add_c   = (ctl.aop == AOP_TARGET) ? 66'($signed({opnd.dlt, 8'b0})) : '0;
	assign sum_w   = acc_q + add_b + add_c;
	assign sum_c32 = clamp32(sum_w);

	always_ff @(posedge clk) begin
		case (ctl.aop)
			AOP_LOAD:    acc_q <= prod_q;
			AOP_LOAD_SH: acc_q <= prod_sh;
			AOP_TARGET:  acc_q <= 66'(sum_c32);
			default:     acc_q <= acc_q;
		endcase
	end

	// integrator clamp
	logic signed [32:0] si_sum, lim_p, lim_n;
	assign si_sum = 33'(si_q) + 33'(fe_q);
	assign lim_p  = $signed({2'b0, cfg.integ_limit, 16'b0});
	assign lim_n  = -lim_p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fe_q <= '0;
			si_q <= '0;
		end else begin
			if (ctl.fe_we) fe_q <= sum_c32;
			if (ctl.si_we) begin
				if (si_sum > lim_p) si_q <= lim_p[31:0];
				else if (si_sum < lim_n) si_q <= lim_n[31:0];
				else si_q <= si_sum[31:0];
			end
		end
	end

	// drive: sum / 2^32 toward zero, then symmetric saturation
	logic signed [33:0] q_w, pwm_p, pwm_n;
	logic               round_up;
	assign round_up = sum_w[65] && (|sum_w[31:0]);
	assign q_w      = $signed(sum_w[65:32]) + $signed({33'b0, round_up});
	assign pwm_p    = $signed({19'b0, cfg.pwm_limit});
	assign pwm_n    = -pwm_p;

	always_comb begin
		if (q_w > pwm_p) drive = pwm_p[15:0];
		else if (q_w < pwm_n) drive = pwm_n[15:0];
		else drive = q_w[15:0];
	end

endmodule

// ===== hw/rtl/balance_cascade_pid.sv =====
// Top level of the cascaded velocity-PI / angle-PD balance controller.
// Each request carries wheel speed, roll angle and roll rate and yields one
// drive command. The outer loop low-pass filters the speed error (weight
// FILTER_ALPHA_Q16/65536 on the old value), integrates it with a clamp of
// +-integ_limit counts, and scales both by vel_kp / vel_ki into a target
// roll angle (plus angle_offset). The inner PD loop turns target-minus-roll
// and the negated roll rate into a drive, truncated toward zero and clamped
// to +-pwm_limit. Roll beyond tilt_limit forces drive to zero and sets
// tilt_cut; the filter and integrator still advance. Each accepted request
// runs through nine sequencer steps that push six products through the
// single 33x33 signed multiplier, each registered before the shared 66-bit
// adder uses it. s_tready is high only while the sequencer is idle. The
// result sits in an output register, so a new request may be taken while
// the previous result still waits; if it is still waiting when the next
// one finishes, the sequencer holds its last step. Config writes are
// always accepted and must be issued only while no request is in flight.
`include "balance_cascade_pid_defines.svh"

module balance_cascade_pid
	import bcp_pkg::*;
#(
	parameter int FILTER_ALPHA_Q16 = FILTER_ALPHA_Q16_DEF
)(
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // enc_speed[15:0], roll_angle[32:16], roll_rate[52:33]
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // drive[15:0]
	output logic [0:0]  m_tuser,   // tilt_cut[0]
	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	// ---- configuration registers ----
	logic signed [31:0] vert_kp_q, vert_kd_q, vel_kp_q, vel_ki_q;
	logic signed [16:0] angle_offset_q;
	logic [15:0]        tilt_limit_q;
	logic [14:0]        pwm_limit_q, integ_limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vert_kp_q      <= VERT_KP_RST;
			vert_kd_q      <= VERT_KD_RST;
			vel_kp_q       <= VEL_KP_RST;
			vel_ki_q       <= VEL_KI_RST;
			angle_offset_q <= ANGLE_OFFSET_RST;
			tilt_limit_q   <= TILT_LIMIT_RST;
			pwm_limit_q    <= PWM_LIMIT_RST;
			integ_limit_q  <= INTEG_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_VERT_KP:      vert_kp_q      <= cfg_data;
				REG_VERT_KD:      vert_kd_q      <= cfg_data;
				REG_VEL_KP:       vel_kp_q       <= cfg_data;
				REG_VEL_KI:       vel_ki_q       <= cfg_data;
				REG_ANGLE_OFFSET: angle_offset_q <= cfg_data[16:0];
				REG_TILT_LIMIT:   tilt_limit_q   <= cfg_data[15:0];
				REG_PWM_LIMIT:    pwm_limit_q    <= cfg_data[14:0];
				REG_INTEG_LIMIT:  integ_limit_q  <= cfg_data[14:0];
				default:          vert_kp_q      <= vert_kp_q;
			endcase
		end
	end

	cfg_t cfg;
	assign cfg.vert_kp     = vert_kp_q;
	assign cfg.vert_kd     = vert_kd_q;
	assign cfg.vel_kp      = vel_kp_q;
	assign cfg.vel_ki      = vel_ki_q;
	assign cfg.pwm_limit   = pwm_limit_q;
	assign cfg.integ_limit = integ_limit_q;

	// ---- request unpack and operand prep ----
	logic signed [15:0] speed_w;
	logic signed [16:0] roll_w;
	logic signed [19:0] rate_w;
	logic [16:0]        roll_mag;
	logic               req_acc;

	assign speed_w  = $signed(s_tdata[15:0]);
	assign roll_w   = $signed(s_tdata[32:16]);
	assign rate_w   = $signed(s_tdata[52:33]);
	// |roll| fits 17 bits unsigned, including the most negative code
	assign roll_mag = roll_w[16] ? 17'(-roll_w) : roll_w;
	assign req_acc  = s_tvalid && s_tready;

	opnd_t opnd_q;
	logic  cut_q;

	always_ff @(posedge clk) begin
		if (req_acc) begin
			opnd_q.err   <= -17'(speed_w);
			opnd_q.dlt   <= 18'(angle_offset_q) - 18'(roll_w);
			opnd_q.nrate <= -29'($signed({rate_w, 8'b0}));
			cut_q        <= (roll_mag > {1'b0, tilt_limit_q});
		end
	end

	// ---- sequencer and datapath ----
	ctl_t               ctl;
	logic               out_free;
	logic signed [15:0] drive_w;

	bcp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (req_acc),
		.out_free (out_free),
		.ctl      (ctl)
	);

	bcp_dp #(
		.FILTER_ALPHA_Q16 (FILTER_ALPHA_Q16)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.cfg    (cfg),
		.opnd   (opnd_q),
		.drive  (drive_w)
	);

	assign s_tready = !ctl.busy;

	// ---- output register ----
	logic        m_tvalid_q;
	logic [15:0] drive_q;
	logic        tilt_cut_q;

	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctl.out_we) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_we) begin
			drive_q    <= cut_q ? '0 : drive_w;
			tilt_cut_q <= cut_q;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = drive_q;
	assign m_tuser[0] = tilt_cut_q;

	// ---- checks ----
	logic signed [15:0] drive_s, pwm_s;
	assign drive_s = $signed(m_tdata);
	assign pwm_s   = $signed({1'b0, pwm_limit_q});

	`BCP_ASSERT_NXT(a_busy_after_req, s_tvalid && s_tready, ctl.busy, "sequencer not started")
	`BCP_ASSERT_IMP(a_no_req_busy, ctl.busy, !s_tready, "request taken while busy")
	`BCP_ASSERT_IMP(a_cut_zero, m_tvalid && m_tuser[0], m_tdata == 16'd0, "tilt cut with drive")
	`BCP_ASSERT_IMP(a_drive_bound, m_tvalid, (drive_s <= pwm_s) && (drive_s >= -pwm_s), "drive over limit")

endmodule

// ===== sim/tb_balance_cascade_pid.sv =====
// Self-checking testbench of the cascaded balance controller: predicts every drive command.
module tb_balance_cascade_pid;
	timeunit 1ns;
	timeprecision 1ps;

	import bcp_pkg::*;

	// One control tick as it travels on s_tdata, encoder speed in the low bits.
	typedef struct packed {
		logic [19:0] rate;
		logic [16:0] roll;
		logic [15:0] speed;
	} tick_t;

	// One predicted result: drive on m_tdata, tilt cut on m_tuser.
	typedef struct packed {
		logic [15:0] drive;
		logic        cut;
	} outcome_t;

	localparam longint ALPHA           = FILTER_ALPHA_Q16_DEF;
	localparam longint S32_MAX         = 64'sd2147483647;
	localparam longint S32_MIN         = -64'sd2147483648;
	localparam int     PHASES          = 10;
	localparam int     TICKS_PER_PHASE = 55;
	localparam int     HOLD_AT_RESULT  = 40;
	localparam int     HOLD_CYCLES     = 400;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata   = '0;    // enc_speed[15:0], roll_angle[32:16], roll_rate[52:33]
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;           // drive[15:0]
	logic [0:0]  m_tuser;           // tilt_cut[0]
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data  = '0;

	balance_cascade_pid u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the registers and of the loop state.
	longint k_vert_p, k_vert_d, k_vel_p, k_vel_i, angle_off;
	longint tilt_lim, pwm_lim, integ_lim;
	longint filt_err, speed_sum;

	tick_t    tick_q[$];            // requests waiting for the driver
	outcome_t drive_expect_q[$];    // predicted results, oldest first

	int queued_total  = 0;
	int results_total = 0;
	int errors        = 0;
	int cut_hits      = 0;
	int sat_hits      = 0;
	int settings_used = 0;

	// Idle shaping, changed between phases only.
	int src_idle_pct  = 30;
	int sink_idle_pct = 30;
	bit calm          = 1'b0;
	int pct_menu [4]  = '{0, 10, 30, 60};

	int gap_cnt   = 0;
	int stall_cnt = 0;
	int hold_cnt  = 0;
	bit hold_done = 1'b0;

	logic [31:0] cfg_set [8];

	function automatic longint clamp(longint v, longint lo, longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Advance the loop state by one tick and return the drive it commands.
	function automatic outcome_t control_tick(tick_t t);
		longint speed, roll, rate, acc, lim, outer, ierr, sum, drv;
		outcome_t res;
		speed = $signed(t.speed);
		roll  = $signed(t.roll);
		rate  = $signed(t.rate);

		// outer loop: low-pass of (0 - speed), floor after the Q16 weighting
		acc = ALPHA * filt_err + (64'sd65536 - ALPHA) * (-speed * 65536);
		filt_err = clamp(acc >>> 16, S32_MIN, S32_MAX);
		lim = integ_lim * 65536;
		speed_sum = clamp(speed_sum + filt_err, -lim, lim);
		outer = ((k_vel_p * filt_err) >>> 16) + ((k_vel_i * speed_sum) >>> 16);

		// inner loop: angles in Q16.16 degrees, error saturated to 32 bits
		ierr = clamp(outer + angle_off * 256 - roll * 256, S32_MIN, S32_MAX);
		sum = k_vert_p * ierr - k_vert_d * (rate * 256);
		drv = (sum >= 0) ? (sum >>> 32) : -((-sum) >>> 32);
		drv = clamp(drv, -pwm_lim, pwm_lim);

		res.cut = ((roll < 0) ? -roll : roll) > tilt_lim;
		if (res.cut) begin
			drv = 0;
			cut_hits++;
		end else if (drv == pwm_lim || drv == -pwm_lim) begin
			sat_hits++;
		end
		res.drive = drv[15:0];
		return res;
	endfunction

	task automatic push_tick(int speed, int roll, int rate);
		tick_t t;
		t.speed = speed[15:0];
		t.roll  = roll[16:0];
		t.rate  = rate[19:0];
		tick_q.push_back(t);
		queued_total++;
	endtask

	// Every queued request has produced its result: the block is idle.
	task automatic wait_drained();
		while (results_total != queued_total)
			@(posedge clk);
	endtask

	// Request driver: holds each request until taken, random gaps between.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			gap_cnt <= 0;
		end else begin
			// predict at acceptance; registers only change while idle
			if (s_tvalid && s_tready)
				drive_expect_q.push_back(control_tick(s_tdata[52:0]));
			if (!s_tvalid || s_tready) begin
				if (gap_cnt != 0) begin
					gap_cnt <= gap_cnt - 1;
					s_tvalid <= 1'b0;
				end else if (tick_q.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (!calm && $urandom_range(99) < src_idle_pct) begin
					// idle burst of random length before the next request
					gap_cnt <= $urandom_range(12);
					s_tvalid <= 1'b0;
				end else begin
					s_tdata <= {3'b000, tick_q.pop_front()};
					s_tvalid <= 1'b1;
				end
			end
		end
	end

	// Result monitor and back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_cnt <= 0;
			hold_cnt <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (drive_expect_q.size() == 0) begin
					$display("%0t: unexpected result: drive %0d, tilt_cut %0b",
						$time, $signed(m_tdata), m_tuser[0]);
					errors++;
				end else begin
					outcome_t want;
					want = drive_expect_q.pop_front();
					if (m_tdata !== want.drive) begin
						$display("%0t: drive mismatch: expected %0d, actual %0d",
							$time, $signed(want.drive), $signed(m_tdata));
						errors++;
					end
					if (m_tuser[0] !== want.cut) begin
						$display("%0t: tilt_cut mismatch: expected %0b, actual %0b",
							$time, want.cut, m_tuser[0]);
						errors++;
					end
				end
				results_total++;
			end

			// one long hold-off so the output register and the sequencer
			// both fill and s_tready drops while requests keep coming
			if (hold_cnt != 0) begin
				hold_cnt <= hold_cnt - 1;
				m_tready <= 1'b0;
			end else if (!hold_done && results_total >= HOLD_AT_RESULT) begin
				hold_done <= 1'b1;
				hold_cnt <= HOLD_CYCLES;
				m_tready <= 1'b0;
			end else if (stall_cnt != 0) begin
				stall_cnt <= stall_cnt - 1;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(99) < sink_idle_pct) begin
				stall_cnt <= $urandom_range(12);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		int p, i, pick, s, a, w;
		int walk_speed, walk_roll;
		reg_idx_t r;

		k_vert_p   = VERT_KP_RST;
		k_vert_d   = VERT_KD_RST;
		k_vel_p    = VEL_KP_RST;
		k_vel_i    = VEL_KI_RST;
		angle_off  = ANGLE_OFFSET_RST;
		tilt_lim   = TILT_LIMIT_RST;
		pwm_lim    = PWM_LIMIT_RST;
		integ_lim  = INTEG_LIMIT_RST;
		filt_err   = 0;
		speed_sum  = 0;
		walk_speed = 0;
		walk_roll  = 0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed ticks on the reset settings: speed extremes, the tilt
		// boundary on both sides, roll and rate extremes, truncation of tiny
		// drives, saturation both ways, integrator pinned at both clamps.
		push_tick(0, 0, 0);
		push_tick(32767, 0, 0);
		push_tick(-32768, 0, 0);
		push_tick(0, 8960, 0);
		push_tick(0, 8961, 0);
		push_tick(0, -8960, 0);
		push_tick(0, -8961, 0);
		push_tick(0, 46080, 0);
		push_tick(0, -46080, 0);
		push_tick(0, 65535, 0);
		push_tick(0, -65536, 0);
		push_tick(0, 0, 524287);
		push_tick(0, 0, -524288);
		push_tick(0, 2000, 0);
		push_tick(0, -2000, 0);
		push_tick(0, 1, 1);
		push_tick(0, -1, -1);
		repeat (4) push_tick(-32768, 0, 0);
		repeat (4) push_tick(32767, 0, 0);
		push_tick(-1, -1, -1);
		wait_drained();

		for (p = 0; p < PHASES; p++) begin
			// moderate settings around a working balance point
			cfg_set[REG_VERT_KP]      = -int'($urandom_range(3000, 200)) * 65536;
			cfg_set[REG_VERT_KD]      = -int'($urandom_range(20 * 65536));
			cfg_set[REG_VEL_KP]       = -int'($urandom_range(20000));
			cfg_set[REG_VEL_KI]       = -int'($urandom_range(200));
			cfg_set[REG_ANGLE_OFFSET] = int'($urandom_range(2048)) - 1024;
			cfg_set[REG_TILT_LIMIT]   = $urandom_range(20000, 2000);
			cfg_set[REG_PWM_LIMIT]    = $urandom_range(32767, 1000);
			cfg_set[REG_INTEG_LIMIT]  = $urandom_range(20000, 100);
			if ($urandom_range(3) == 0) begin
				cfg_set[REG_VEL_KP] = -cfg_set[REG_VEL_KP];
				cfg_set[REG_VEL_KI] = -cfg_set[REG_VEL_KI];
			end
			case (p)
				0: begin
					cfg_set[REG_VERT_KP]      = VERT_KP_RST;
					cfg_set[REG_VERT_KD]      = VERT_KD_RST;
					cfg_set[REG_VEL_KP]       = VEL_KP_RST;
					cfg_set[REG_VEL_KI]       = VEL_KI_RST;
					cfg_set[REG_ANGLE_OFFSET] = 32'(signed'(ANGLE_OFFSET_RST));
					cfg_set[REG_TILT_LIMIT]   = TILT_LIMIT_RST;
					cfg_set[REG_PWM_LIMIT]    = PWM_LIMIT_RST;
					cfg_set[REG_INTEG_LIMIT]  = INTEG_LIMIT_RST;
				end
				2: begin
					// gains, drive limit and integrator limit at their top
					cfg_set[REG_VERT_KP]      = 32'h7FFF_FFFF;
					cfg_set[REG_VERT_KD]      = 32'h7FFF_FFFF;
					cfg_set[REG_VEL_KP]       = 32'h7FFF_FFFF;
					cfg_set[REG_VEL_KI]       = 32'h7FFF_FFFF;
					cfg_set[REG_ANGLE_OFFSET] = 46080;
					cfg_set[REG_TILT_LIMIT]   = 46080;
					cfg_set[REG_PWM_LIMIT]    = 32767;
					cfg_set[REG_INTEG_LIMIT]  = 32767;
				end
				3: begin
					// gains at their bottom; limits of zero
					cfg_set[REG_VERT_KP]      = 32'h8000_0000;
					cfg_set[REG_VERT_KD]      = 32'h8000_0000;
					cfg_set[REG_VEL_KP]       = 32'h8000_0000;
					cfg_set[REG_VEL_KI]       = 32'h8000_0000;
					cfg_set[REG_ANGLE_OFFSET] = -46080;
					cfg_set[REG_TILT_LIMIT]   = 0;
					cfg_set[REG_PWM_LIMIT]    = 0;
					cfg_set[REG_INTEG_LIMIT]  = 0;
				end
				4: begin
					// raw words: upper bits of the narrow registers are dropped
					foreach (cfg_set[j])
						cfg_set[j] = $urandom;
				end
				5: begin
					cfg_set[REG_TILT_LIMIT] = 16'hFFFF;
					cfg_set[REG_PWM_LIMIT]  = 32767;
				end
				6: begin
					// integrator slams into a tight clamp
					cfg_set[REG_VEL_KP]      = 0;
					cfg_set[REG_VEL_KI]      = -int'($urandom_range(200000, 20000));
					cfg_set[REG_INTEG_LIMIT] = $urandom_range(40, 1);
					cfg_set[REG_TILT_LIMIT]  = 16'hFFFF;
				end
				default: ;
			endcase

			// write all eight registers; the block is idle here
			r = r.first();
			do begin
				cfg_valid <= 1'b1;
				cfg_index <= r;
				cfg_data  <= cfg_set[r];
				do @(posedge clk); while (!cfg_ready);
				case (r)
					REG_VERT_KP:      k_vert_p  = $signed(cfg_set[r]);
					REG_VERT_KD:      k_vert_d  = $signed(cfg_set[r]);
					REG_VEL_KP:       k_vel_p   = $signed(cfg_set[r]);
					REG_VEL_KI:       k_vel_i   = $signed(cfg_set[r]);
					REG_ANGLE_OFFSET: angle_off = $signed(cfg_set[r][16:0]);
					REG_TILT_LIMIT:   tilt_lim  = cfg_set[r][15:0];
					REG_PWM_LIMIT:    pwm_lim   = cfg_set[r][14:0];
					REG_INTEG_LIMIT:  integ_lim = cfg_set[r][14:0];
					default: ;
				endcase
				cfg_valid <= 1'b0;
				@(posedge clk);
				r = r.next();
			end while (r != r.first());
			settings_used++;

			// last phase runs without any idling
			if (p == PHASES - 1) begin
				calm = 1'b1;
			end else begin
				src_idle_pct  = pct_menu[2'($urandom_range(3))];
				sink_idle_pct = pct_menu[2'($urandom_range(3))];
			end

			for (i = 0; i < TICKS_PER_PHASE; i++) begin
				pick = $urandom_range(99);
				if (pick < 60) begin
					// slowly wandering plant: speed and roll drift, rate is noise
					walk_speed = int'(clamp(walk_speed + int'($urandom_range(80)) - 40,
						-3000, 3000));
					walk_roll  = int'(clamp(walk_roll + int'($urandom_range(400)) - 200,
						-12000, 12000));
					s = walk_speed;
					a = walk_roll;
					w = int'($urandom_range(60000)) - 30000;
				end else if (pick < 85) begin
					// any bit pattern of the fields
					s = $urandom;
					a = $urandom;
					w = $urandom;
				end else begin
					case ($urandom_range(3))
						0: s = -32768;
						1: s = 32767;
						2: s = 0;
						default: s = -1;
					endcase
					case ($urandom_range(5))
						0: a = -65536;
						1: a = 65535;
						2: a = 46080;
						3: a = -46080;
						4: a = int'(tilt_lim);
						default: a = -int'(tilt_lim) - 1;
					endcase
					case ($urandom_range(3))
						0: w = -524288;
						1: w = 524287;
						2: w = 0;
						default: w = -1;
					endcase
				end
				push_tick(s, a, w);
			end
			wait_drained();
		end

		repeat (20) @(posedge clk);
		$display("Ran %0d control ticks under %0d register settings plus reset values.",
			results_total, settings_used);
		$display("%0d ticks hit the tilt cut, %0d drives sat at the drive limit.",
			cut_hits, sat_hits);
		if (errors == 0 && drive_expect_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5000000;
		$display("FAILURE");
		$finish;
	end

endmodule
